### sv/jia_pkg.sv
`default_nettype none
package jia_pkg;

    localparam int NUM_SLOTS   = 192;
    localparam int SLOT_W      = $clog2(NUM_SLOTS);
    localparam int AUTO_SLOTS  = NUM_SLOTS - 2;
    localparam int VERIFY_SLOT = NUM_SLOTS - 2;
    localparam int ADDR_W      = 3;

    localparam logic [2:0] OP_ALLOC    = 3'd0;
    localparam logic [2:0] OP_REPORT   = 3'd1;
    localparam logic [2:0] OP_REL_SLOT = 3'd2;
    localparam logic [2:0] OP_REL_TASK = 3'd3;
    localparam logic [2:0] OP_QUERY    = 3'd4;
    localparam logic [2:0] OP_ALL_DONE = 3'd5;
    localparam logic [2:0] OP_ALL_OK   = 3'd6;
    localparam logic [2:0] OP_TICK     = 3'd7;

    localparam logic REG_VERIFY = 1'b0;
    localparam logic REG_HOLD   = 1'b1;

    typedef struct packed {
        logic [2:0] cmd;
        logic [7:0] task_id;
        logic [7:0] slot_id;
        logic [7:0] succ_flags;
    } t_req;

    typedef struct packed {
        logic       granted;
        logic [7:0] slot_out;
        logic       done_res;
        logic [7:0] succ_out;
        logic       all_done;
        logic       all_succ;
    } t_rsp;

    typedef struct packed {
        logic       fin;
        logic [7:0] owner;
        logic [7:0] result;
        logic [7:0] timer;
    } t_entry;

    typedef struct packed {
        logic              load;
        logic              probe;
        logic              vfy;
        logic              rd;
        logic              rd_one;
        logic              fin;
        logic [2:0]        op;
        logic [SLOT_W-1:0] addr;
    } t_dp_cmd;

    typedef struct packed {
        logic              verify;
        logic              free;
        logic [SLOT_W-1:0] start;
    } t_dp_sts;

endpackage
`default_nettype wire

### sv/jia_ctrl.sv
`default_nettype none
module jia_ctrl import jia_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_start,
    input  logic [2:0] i_op,
    input  t_dp_sts    i_sts,
    output logic       o_busy,
    output t_dp_cmd    o_cmd
);

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_ALLOC = 3'd1;
    localparam logic [2:0] S_RD    = 3'd2;
    localparam logic [2:0] S_SCAN  = 3'd3;
    localparam logic [2:0] S_LAST  = 3'd4;

    logic [2:0]        r_state, n_state;
    logic [SLOT_W-1:0] r_ptr, n_ptr;
    logic [SLOT_W-1:0] r_cnt, n_cnt;
    logic [2:0]        r_op, n_op;

    always_comb begin
        n_state    = r_state;
        n_ptr      = r_ptr;
        n_cnt      = r_cnt;
        n_op       = r_op;
        o_cmd      = '0;
        o_cmd.op   = r_op;
        o_cmd.addr = r_ptr;
        unique case (r_state)
            S_IDLE: begin
                if (i_start) begin
                    o_cmd.load = 1'b1;
                    n_op       = i_op;
                    unique case (i_op) inside
                        OP_ALLOC: begin
                            n_state = S_ALLOC;
                            n_ptr   = i_sts.start;
                            n_cnt   = '0;
                        end
                        OP_REPORT, OP_QUERY: n_state = S_RD;
                        OP_REL_SLOT:         n_state = S_LAST;
                        default: begin
                            n_state = S_SCAN;
                            n_ptr   = '0;
                        end
                    endcase
                end
            end
            S_ALLOC: begin
                if (i_sts.verify) begin
                    o_cmd.vfy = 1'b1;
                    n_state   = S_LAST;
                end else begin
                    o_cmd.probe = 1'b1;
                    if (i_sts.free || r_cnt == SLOT_W'(AUTO_SLOTS - 1)) begin
                        n_state = S_LAST;
                    end else begin
                        n_ptr = (r_ptr == SLOT_W'(AUTO_SLOTS - 1)) ? '0 : r_ptr + 1'b1;
                        n_cnt = r_cnt + 1'b1;
                    end
                end
            end
            S_RD: begin
                o_cmd.rd_one = 1'b1;
                n_state      = S_LAST;
            end
            S_SCAN: begin
                o_cmd.rd = 1'b1;
                if (r_ptr == SLOT_W'(NUM_SLOTS - 1)) begin
                    n_state = S_LAST;
                end else begin
                    n_ptr = r_ptr + 1'b1;
                end
            end
            S_LAST: begin
                o_cmd.fin = 1'b1;
                n_state   = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_ptr   <= '0;
            r_cnt   <= '0;
            r_op    <= OP_ALLOC;
        end else begin
            r_state <= n_state;
            r_ptr   <= n_ptr;
            r_cnt   <= n_cnt;
            r_op    <= n_op;
        end
    end

    assign o_busy = (r_state != S_IDLE);

endmodule
`default_nettype wire

### sv/jia_dp.sv
`default_nettype none
module jia_dp import jia_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  t_req       i_req,
    input  t_dp_cmd    i_cmd,
    input  logic [7:0] i_verify_id,
    input  logic [7:0] i_hold_ticks,
    output t_dp_sts    o_sts,
    output logic       o_valid,
    output t_rsp       o_rsp
);

    logic [7:0]           r_task;
    logic [7:0]           r_slot;
    logic [7:0]           r_flags;
    logic [NUM_SLOTS-1:0] r_assigned, n_assigned;
    logic [SLOT_W-1:0]    r_last, n_last;
    logic                 r_rd_vld;
    logic [SLOT_W-1:0]    r_rd_addr;
    t_entry               r_rdata;
    t_rsp                 r_res, n_res;
    logic                 r_out_vld;
    logic [$bits(t_entry)-1:0] r_mem [NUM_SLOTS];

    logic              slot_ok;
    logic [SLOT_W-1:0] slot_idx;
    logic              slot_asg;
    logic              own_hit;
    logic [7:0]        tick_t;
    logic [SLOT_W:0]   nxt;
    logic              rd_en;
    logic [SLOT_W-1:0] rd_addr;
    logic              grant;
    logic              we;
    logic [SLOT_W-1:0] wa;
    t_entry            wd;

    assign slot_ok  = (9'(r_slot) < 9'(NUM_SLOTS));
    assign slot_idx = r_slot[SLOT_W-1:0];
    assign slot_asg = slot_ok && r_assigned[slot_idx];
    assign own_hit  = r_assigned[r_rd_addr] && (r_rdata.owner == r_task);
    assign tick_t   = r_rdata.timer + 8'd1;
    assign nxt      = {1'b0, r_last} + 1'b1;
    assign rd_en    = i_cmd.rd | (i_cmd.rd_one & slot_ok);
    assign rd_addr  = i_cmd.rd_one ? slot_idx : i_cmd.addr;
    assign grant    = i_cmd.probe && !r_assigned[i_cmd.addr];

    assign o_sts.verify = (r_task == i_verify_id);
    assign o_sts.free   = !r_assigned[i_cmd.addr];
    assign o_sts.start  = (nxt >= (SLOT_W+1)'(AUTO_SLOTS)) ? '0 : nxt[SLOT_W-1:0];

    always_comb begin
        n_assigned = r_assigned;
        n_last     = r_last;
        n_res      = r_res;
        we         = 1'b0;
        wa         = i_cmd.addr;
        wd         = r_rdata;
        if (i_cmd.load) begin
            n_res          = '0;
            n_res.all_done = (i_req.cmd == OP_ALL_DONE);
            n_res.all_succ = (i_req.cmd == OP_ALL_OK);
        end
        if (i_cmd.vfy) begin
            n_res.granted  = 1'b1;
            n_res.slot_out = 8'(VERIFY_SLOT);
        end
        if (grant) begin
            n_assigned[i_cmd.addr] = 1'b1;
            n_last                 = i_cmd.addr;
            n_res.granted          = 1'b1;
            n_res.slot_out         = 8'(i_cmd.addr);
            we                     = 1'b1;
            wa                     = i_cmd.addr;
            wd                     = '0;
            wd.owner               = r_task;
        end
        if (r_rd_vld) begin
            case (i_cmd.op)
                OP_REL_TASK: begin
                    if (own_hit) n_assigned[r_rd_addr] = 1'b0;
                end
                OP_ALL_DONE: begin
                    if (own_hit && !r_rdata.fin) n_res.all_done = 1'b0;
                end
                OP_ALL_OK: begin
                    if (own_hit && (!r_rdata.fin || r_rdata.result == 8'd0)) begin
                        n_res.all_succ = 1'b0;
                    end
                end
                OP_TICK: begin
                    if (r_assigned[r_rd_addr] && r_rdata.fin) begin
                        if (tick_t >= i_hold_ticks) begin
                            n_assigned[r_rd_addr] = 1'b0;
                        end else begin
                            we       = 1'b1;
                            wa       = r_rd_addr;
                            wd.timer = tick_t;
                        end
                    end
                end
                default: ;
            endcase
        end
        if (i_cmd.fin) begin
            case (i_cmd.op)
                OP_REPORT: begin
                    if (slot_asg) begin
                        we        = 1'b1;
                        wa        = slot_idx;
                        wd.fin    = 1'b1;
                        wd.result = r_flags;
                    end
                end
                OP_REL_SLOT: begin
                    if (slot_ok) n_assigned[slot_idx] = 1'b0;
                end
                OP_QUERY: begin
                    if (!slot_asg) begin
                        n_res.done_res = 1'b1;
                    end else if (r_rdata.fin) begin
                        n_res.done_res = 1'b1;
                        n_res.succ_out = r_rdata.result;
                    end
                end
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_assigned <= '0;
            r_last     <= '0;
            r_rd_vld   <= 1'b0;
            r_out_vld  <= 1'b0;
        end else begin
            r_assigned <= n_assigned;
            r_last     <= n_last;
            r_rd_vld   <= rd_en;
            r_out_vld  <= i_cmd.fin;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_task  <= i_req.task_id;
            r_slot  <= i_req.slot_id;
            r_flags <= i_req.succ_flags;
        end
        r_res     <= n_res;
        r_rd_addr <= rd_addr;
    end

    always_ff @(posedge i_clk) begin
        if (we) r_mem[wa] <= wd;
        if (rd_en) r_rdata <= r_mem[rd_addr];
    end

    assign o_valid = r_out_vld;
    assign o_rsp   = r_res;

endmodule
`default_nettype wire

### sv/job_id_allocator_with_timeout_unit.sv
// Job slot allocator with round-robin grant and result hold timeout. A command
// is taken when start is high and busy is low; its single result appears on
// o_rsp for exactly one cycle with o_valid high, after the transfer, and the
// receiver cannot stall it. Busy time is set by the slot table, which has one
// read port and is walked one slot per cycle: release slot goes straight to
// the last state; report, query slot and verify-task allocate take one read or
// verify step first; allocate probes one slot per cycle until a slot is free
// or all AUTO_SLOTS are probed; release task, task queries and tick walk all
// NUM_SLOTS slots. The strobe follows the last busy cycle. Reset is synchronous.
`default_nettype none
module job_id_allocator_with_timeout_unit import jia_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              start,
    output logic              busy,
    input  t_req              i_req,
    output logic              o_valid,
    output t_rsp              o_rsp,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [ADDR_W-1:0] paddr,
    input  logic [31:0]       pwdata,
    output logic [31:0]       prdata,
    output logic              pready
);

    logic [7:0] r_verify_id;
    logic [7:0] r_hold_ticks;
    logic       cfg_wr;
    t_dp_cmd    dp_cmd;
    t_dp_sts    dp_sts;

    assign pready = 1'b1;
    assign cfg_wr = psel & penable & pwrite;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_verify_id  <= 8'd255;
            r_hold_ticks <= 8'd30;
        end else if (cfg_wr) begin
            unique case (paddr[2])
                REG_VERIFY: r_verify_id  <= pwdata[7:0];
                REG_HOLD:   r_hold_ticks <= pwdata[7:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (paddr[2])
            REG_VERIFY: prdata = {24'd0, r_verify_id};
            REG_HOLD:   prdata = {24'd0, r_hold_ticks};
            default:    prdata = '0;
        endcase
    end

    jia_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (start),
        .i_op    (i_req.cmd),
        .i_sts   (dp_sts),
        .o_busy  (busy),
        .o_cmd   (dp_cmd)
    );

    jia_dp u_dp (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_req        (i_req),
        .i_cmd        (dp_cmd),
        .i_verify_id  (r_verify_id),
        .i_hold_ticks (r_hold_ticks),
        .o_sts        (dp_sts),
        .o_valid      (o_valid),
        .o_rsp        (o_rsp)
    );

    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        start && !busy |=> busy)
        else $error("busy not raised after command transfer");

    a_result_after_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> $past(busy))
        else $error("result strobe without preceding work");

    a_single_strobe: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |=> !o_valid)
        else $error("result strobe repeated");

    a_grant_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_rsp.granted |-> o_rsp.slot_out <= 8'(VERIFY_SLOT))
        else $error("granted slot out of range");

endmodule
`default_nettype wire
